@@ rtl/core/spq_pkg.sv @@
package spq_pkg;

  // Operation codes carried on the request's tuser bit.
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_POP    = 1'b1;

  localparam int PRI_W = 16;
  localparam int TAG_W = 16;
  localparam int LEN_W = 5;

  typedef struct packed {
    logic [TAG_W-1:0]        tag;
    logic signed [PRI_W-1:0] pri;
  } entry_t;

  // Broadcast from the top level to every cell in the chain.
  typedef struct packed {
    logic   ins;
    logic   pop;
    entry_t new_ent;
  } cell_ctrl_t;

endpackage

@@ rtl/core/spq_cell.sv @@
module spq_cell
  import spq_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       occupied,
  input  logic       left_stay,
  input  entry_t     left_ent,
  input  entry_t     right_ent,
  output logic       stay,
  output entry_t     ent
);

  entry_t entry_r;
  entry_t entry_nxt;

  // Hold the entry on insert when it ranks at or before the new one.
  assign stay = occupied && (entry_r.pri <= ctrl.new_ent.pri);
  assign ent  = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.ins && !stay) begin
      entry_nxt = left_stay ? ctrl.new_ent : left_ent;
    end else if (ctrl.pop) begin
      entry_nxt = right_ent;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

@@ rtl/core/stable_priority_queue_unit.sv @@
// Stable sorted priority queue built as a chain of shift cells.
// A request's result is registered on acceptance and is valid in the next cycle.
// Throughput: one insert or pop per cycle unless the output stalls; all cells compare in parallel.
// Reset (rst_n low, synchronous): queue empties, output valid clears.
// Entry storage is not reset; only cells below the fill count are read.
module stable_priority_queue_unit
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] priority_req, [31:16] job_tag
  input  logic        in_tuser,   // [0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [15:0] popped_priority, [31:16] popped_tag,
                                  // [36:32] queue_length, [39:37] zero
  output logic [1:0]  out_tuser   // [0] popped_valid, [1] insert_dropped
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_tvalid_r;
  logic [39:0]      out_tdata_r;
  logic [1:0]       out_tuser_r;

  logic       in_fire;
  logic       is_ins;
  logic       is_pop;
  logic       full;
  logic       empty;
  cell_ctrl_t ctrl;

  entry_t ents  [QUEUE_DEPTH];
  logic   stays [QUEUE_DEPTH];

  // Take a new request whenever the output register is free or draining.
  assign in_tready = !out_tvalid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign is_ins    = (in_tuser == KIND_INSERT);
  assign is_pop    = (in_tuser == KIND_POP);
  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty     = (count_r == '0);

  assign ctrl.ins         = in_fire && is_ins && !full;
  assign ctrl.pop         = in_fire && is_pop && !empty;
  assign ctrl.new_ent.pri = in_tdata[15:0];
  assign ctrl.new_ent.tag = in_tdata[31:16];

  // Chain of cells: cell 0 is the head. Insert shifts the tail right,
  // pop shifts everything left by one.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic   occ;
    logic   l_stay;
    entry_t l_ent;
    entry_t r_ent;

    assign occ = (CNT_W'(i) < count_r);

    if (i == 0) begin : g_head
      assign l_stay = 1'b1;
      assign l_ent  = ctrl.new_ent;
    end else begin : g_body
      assign l_stay = stays[i-1];
      assign l_ent  = ents[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign r_ent = ents[i];
    end else begin : g_mid
      assign r_ent = ents[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occupied  (occ),
      .left_stay (l_stay),
      .left_ent  (l_ent),
      .right_ent (r_ent),
      .stay      (stays[i]),
      .ent       (ents[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (ctrl.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctrl.pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // Length field carries the count masked to its five bits.
  logic [CNT_W+LEN_W-1:0] len_ext;
  assign len_ext = (CNT_W+LEN_W)'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (in_fire) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_tdata_r[15:0]  <= ctrl.pop ? ents[0].pri : '0;
      out_tdata_r[31:16] <= ctrl.pop ? ents[0].tag : '0;
      out_tdata_r[36:32] <= len_ext[LEN_W-1:0];
      out_tdata_r[39:37] <= '0;
      out_tuser_r[0]     <= ctrl.pop;
      out_tuser_r[1]     <= is_ins && full;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("fill count exceeds queue depth");

  a_ins_grows : assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.ins |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not grow the queue");

  a_flags_excl : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> !(out_tuser_r[0] && out_tuser_r[1]))
    else $error("pop and drop flagged together");

  a_head_sorted : assert property (@(posedge clk) disable iff (!rst_n)
    count_r >= CNT_W'(2) |-> ents[0].pri <= ents[1].pri)
    else $error("head entries out of order");

  a_drop_full : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && is_ins && full |=> $stable(count_r))
    else $error("dropped insert changed the queue");

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import spq_pkg::*;

  localparam int QUEUE_DEPTH = 16;
  localparam int HOLD_CYCLES = 80;   // long receiver stall, fills the output register
  localparam int HOLD_AT     = 150;  // result count that triggers the stall
  localparam int CALM_FIRST  = 300;  // window with no idling on either side
  localparam int CALM_LAST   = 420;

  // One queued request for the driver; drain marks a pause until all results are in.
  typedef struct {
    logic                    kind;
    logic signed [PRI_W-1:0] pri;
    logic [TAG_W-1:0]        tag;
    bit                      calm;
    bit                      drain;
  } request_t;

  // Expected result of one request.
  typedef struct packed {
    logic                    popped_valid;
    logic signed [PRI_W-1:0] popped_pri;
    logic [TAG_W-1:0]        popped_tag;
    logic [LEN_W-1:0]        qlen;
    logic                    dropped;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // [15:0] priority_req, [31:16] job_tag
  logic        in_tuser = 1'b0; // [0] kind
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // [15:0] popped_priority, [31:16] popped_tag, [36:32] length
  logic [1:0]  out_tuser;       // [0] popped_valid, [1] insert_dropped

  stable_priority_queue_unit #(.QUEUE_DEPTH(QUEUE_DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  request_t pending[$];     // requests not yet offered
  outcome_t awaited[$];     // results predicted, not yet seen

  // Shadow of the sorted store, head at index 0.
  entry_t held[QUEUE_DEPTH];
  int     held_count = 0;

  bit req_taken = 1'b0;     // last rising edge moved a request
  int requests_done = 0;
  int results_seen = 0;
  int mismatches = 0;
  int n_served = 0;
  int n_empty_pops = 0;
  int n_dropped = 0;
  int peak_len = 0;

  // Apply one request to the shadow store and return what the block must answer.
  function automatic outcome_t apply_request(logic kind, logic signed [PRI_W-1:0] pri,
                                             logic [TAG_W-1:0] tag);
    outcome_t o;
    int pos;
    int i;
    o = '0;
    if (kind == KIND_INSERT) begin
      if (held_count >= QUEUE_DEPTH) begin
        o.dropped = 1'b1;
        n_dropped++;
      end else begin
        // Skip every entry with priority <= new one so ties keep arrival order.
        pos = 0;
        while (pos < held_count && held[pos].pri <= pri) pos++;
        for (i = held_count; i > pos; i--) held[i] = held[i-1];
        held[pos].pri = pri;
        held[pos].tag = tag;
        held_count++;
        if (held_count > peak_len) peak_len = held_count;
      end
    end else if (held_count > 0) begin
      o.popped_valid = 1'b1;
      o.popped_pri   = held[0].pri;
      o.popped_tag   = held[0].tag;
      for (i = 1; i < held_count; i++) held[i-1] = held[i];
      held_count--;
      n_served++;
    end else begin
      n_empty_pops++;
    end
    o.qlen = LEN_W'(held_count);
    return o;
  endfunction

  function automatic void check_field(string name, int want_v, int got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d (result %0d)", name, want_v, got_v, results_seen);
      mismatches++;
    end
  endfunction

  task automatic queue_request(logic kind, logic [15:0] pri, logic [15:0] tag, bit calm);
    request_t r;
    r.kind  = kind;
    r.pri   = pri;
    r.tag   = tag;
    r.calm  = calm;
    r.drain = 1'b0;
    pending = {pending, r};
  endtask

  task automatic queue_drain();
    request_t r;
    r = '{default: '0};
    r.drain = 1'b1;
    pending = {pending, r};
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  // Hold reset at the start, release it on a falling edge.
  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
  end

  // Driver: advance to the next request only once the current one is taken.
  always @(negedge clk) begin
    request_t nxt;
    if (rst_n && (!in_tvalid || req_taken)) begin
      if (pending.size() == 0) begin
        in_tvalid <= 1'b0;
      end else if (pending[0].drain) begin
        // Pause the sender until every predicted result has come back.
        in_tvalid <= 1'b0;
        if (awaited.size() == 0) void'(pending.pop_front());
      end else if (!pending[0].calm && $urandom_range(99) < 28) begin
        in_tvalid <= 1'b0;
      end else begin
        nxt = pending.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= nxt.kind;
        in_tdata  <= {nxt.tag, nxt.pri};
      end
    end
  end

  // Receiver: random backpressure, one long stall, one calm stretch.
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      // Stall long enough that the block backs up and drops in_tready.
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_tready <= 1'b0;
    end else if (results_seen >= CALM_FIRST && results_seen < CALM_LAST) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= 28);
    end
  end

  // Monitor: predict on request acceptance, check on result acceptance.
  always @(posedge clk) begin
    outcome_t want;
    outcome_t pred;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        pred = apply_request(in_tuser, in_tdata[15:0], in_tdata[31:16]);
        awaited = {awaited, pred};
        requests_done++;
      end
      req_taken <= in_tvalid && in_tready;
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (awaited.size() == 0) begin
          $error("unexpected result: no request outstanding (result %0d)", results_seen);
          mismatches++;
        end else begin
          want = awaited.pop_front();
          check_field("popped_valid", int'(want.popped_valid), int'(out_tuser[0]));
          check_field("popped_priority", int'(want.popped_pri),
                      int'($signed(out_tdata[15:0])));
          check_field("popped_tag", int'(want.popped_tag), int'(out_tdata[31:16]));
          check_field("queue_length", int'(want.qlen), int'(out_tdata[36:32]));
          check_field("insert_dropped", int'(want.dropped), int'(out_tuser[1]));
          check_field("tdata_pad", 0, int'(out_tdata[39:37]));
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int dir_pri[16];
    int bias;
    int seg;
    int k;
    int n;
    int pri;
    logic kind;

    dir_pri = '{5, -32768, 32767, 5, 0, -1, 5, -32768, 32767, 5, 0, 1, -2, 100, -100, 5};

    // Directed: pop on empty with junk fields, fill with extremes and ties,
    // insert into full, then pops to check order.
    queue_request(KIND_POP, 16'h8001, 16'hFFFF, 1'b0);
    for (k = 0; k < 16; k++)
      queue_request(KIND_INSERT, 16'(dir_pri[k]), (k == 1) ? 16'hFFFF : 16'(k), 1'b0);
    queue_request(KIND_INSERT, 16'h7FFF, 16'hAAAA, 1'b0);
    queue_drain();
    for (k = 0; k < 6; k++) queue_request(KIND_POP, 16'($urandom), 16'($urandom), 1'b0);
    queue_drain();

    // Random: segments biased to fill, mix, drain or anything in between.
    n = 0;
    for (seg = 0; seg < 16; seg++) begin
      case (seg % 4)
        0: bias = 85;
        1: bias = 50;
        2: bias = 15;
        default: bias = $urandom_range(100);
      endcase
      for (k = 0; k < 40; k++) begin
        kind = ($urandom_range(99) < bias) ? KIND_INSERT : KIND_POP;
        case ($urandom_range(3))
          0: pri = int'($urandom_range(6)) - 3;  // dense ties
          1: pri = $urandom;
          2: pri = $urandom_range(1) ? -32768 : 32767;
          default: pri = $urandom_range(15);
        endcase
        queue_request(kind, 16'(pri), 16'($urandom), n >= CALM_FIRST && n < CALM_LAST);
        n++;
      end
      if (seg == 7) queue_drain();
    end

    // Hold until every request is sent and answered, then let the pipe settle.
    while (pending.size() != 0 || in_tvalid || awaited.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Covered %0d requests: %0d entries served, %0d pops on empty, %0d inserts dropped,",
             requests_done, n_served, n_empty_pops, n_dropped);
    $display("peak length %0d, results checked %0d, mismatches %0d",
             peak_len, results_seen, mismatches);
    if (mismatches == 0 && awaited.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Hard limit far above the slowest correct run.
  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/stable_priority_queue_unit.sv
bench/testbench.sv
